/* rtl/kpm_pkg.sv */
// ----------------------------------------------------------------------------
// kpm_pkg
// Shared types and constants for the key partition mapper: payload structs,
// mode and register codes, controller states and control/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package kpm_pkg;

  // fnv-1 constants
  localparam logic [31:0] FNV_BASIS = 32'h811c_9dc5;
  localparam logic [31:0] FNV_PRIME = 32'h0100_0193;

  // width of the decimal value and of the divider dividend
  localparam int unsigned DIV_W   = 63;
  localparam int unsigned CNT_W   = $clog2(DIV_W);
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned CFG_W   = 16;

  // register indexes on the configuration port
  localparam logic [IDX_W-1:0] REG_MODE       = 3'd0;
  localparam logic [IDX_W-1:0] REG_NUM_PART   = 3'd1;
  localparam logic [IDX_W-1:0] REG_LOCAL_PART = 3'd2;
  localparam logic [IDX_W-1:0] REG_NUM_REGION = 3'd3;
  localparam logic [IDX_W-1:0] REG_PREFIX     = 3'd4;

  typedef enum logic [1:0] {
    MODE_HASH    = 2'd0,
    MODE_DEC_MOD = 2'd1,
    MODE_DEC_DIV = 2'd2,
    MODE_WORD    = 2'd3
  } kpm_mode_t;

  typedef struct packed {
    logic [7:0] key_byte;
    logic       last_byte;
  } kpm_in_t;

  typedef struct packed {
    logic [15:0] partition;
    logic        is_local;
    logic        bad_key;
  } kpm_out_t;

  typedef struct packed {
    kpm_mode_t   mode;
    logic [15:0] part_count;
    logic [15:0] own_part;
    logic [7:0]  region_count;
    logic [15:0] key_prefix_bytes;
  } kpm_cfg_t;

  typedef enum logic [2:0] {
    ST_BYTES,
    ST_LOAD1,
    ST_DIV1,
    ST_LOAD2,
    ST_DIV2,
    ST_RESULT
  } kpm_state_t;

  // controller to datapath
  typedef struct packed {
    logic byte_en;
    logic clear_key;
    logic load_first;
    logic load_second;
    logic div_step;
    logic result_load;
  } kpm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_last;
    logic two_pass;
    logic out_free;
  } kpm_stat_t;

endpackage

`default_nettype wire

/* rtl/kpm_ctrl.sv */
// ----------------------------------------------------------------------------
// kpm_ctrl
// Controller: takes key bytes, then sequences one or two divider passes and
// hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module kpm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              in_last,
  output logic                   in_ready,
  input  wire kpm_pkg::kpm_stat_t stat,
  output kpm_pkg::kpm_cmd_t      cmd
);

  kpm_pkg::kpm_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kpm_pkg::ST_BYTES;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      kpm_pkg::ST_BYTES: begin
        in_ready    = 1'b1;
        cmd.byte_en = in_valid;
        if (in_valid && in_last) begin
          state_next = kpm_pkg::ST_LOAD1;
        end
      end
      kpm_pkg::ST_LOAD1: begin
        cmd.load_first = 1'b1;
        cmd.clear_key  = 1'b1;
        state_next     = kpm_pkg::ST_DIV1;
      end
      kpm_pkg::ST_DIV1: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = stat.two_pass ? kpm_pkg::ST_LOAD2 : kpm_pkg::ST_RESULT;
        end
      end
      kpm_pkg::ST_LOAD2: begin
        cmd.load_second = 1'b1;
        state_next      = kpm_pkg::ST_DIV2;
      end
      kpm_pkg::ST_DIV2: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = kpm_pkg::ST_RESULT;
        end
      end
      kpm_pkg::ST_RESULT: begin
        if (stat.out_free) begin
          cmd.result_load = 1'b1;
          state_next      = kpm_pkg::ST_BYTES;
        end
      end
      default: begin
        state_next = kpm_pkg::ST_BYTES;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/kpm_datapath.sv */
// ----------------------------------------------------------------------------
// kpm_datapath
// Per-byte key accumulators (fnv-1 hash, decimal parse, little-endian word),
// a bit-serial restoring divider and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module kpm_datapath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire kpm_pkg::kpm_cfg_t cfg,
  input  wire kpm_pkg::kpm_in_t  in_data,
  input  wire kpm_pkg::kpm_cmd_t cmd,
  output kpm_pkg::kpm_stat_t     stat,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output kpm_pkg::kpm_out_t      out_data
);

  localparam logic [62:0] DEC_LIMIT = {63{1'b1}};

  // key state
  logic [31:0]               hash;
  logic [15:0]               bytes_seen;
  logic [kpm_pkg::DIV_W-1:0] dec_value;
  logic                      digits_ended;
  logic                      number_bad;
  logic [31:0]               wh_word;

  // divider state
  logic [kpm_pkg::DIV_W-1:0] div_q;
  logic [15:0]               div_rem;
  logic [15:0]               div_den;
  logic [kpm_pkg::CNT_W-1:0] div_cnt;
  logic                      key_bad;

  // per-byte next values
  logic [31:0]               hash_mul;
  logic                      is_digit;
  logic [66:0]               dec_sum;
  logic                      dec_over;
  logic [15:0]               part_den;
  logic [15:0]               region_den;
  logic [kpm_pkg::DIV_W-1:0] first_dividend;
  logic [16:0]               trial;
  logic [16:0]               trial_diff;
  logic                      trial_ge;
  logic [15:0]               part_res;

  // fnv-1 multiply, xor applied at the register
  assign hash_mul = hash * kpm_pkg::FNV_PRIME;

  // decimal step: value*10 + digit, overflow when above 2^63-1
  assign is_digit = (in_data.key_byte >= 8'h30) && (in_data.key_byte <= 8'h39);
  assign dec_sum  = ({4'b0, dec_value} << 3) + ({4'b0, dec_value} << 1)
                  + {63'b0, in_data.key_byte[3:0]};
  assign dec_over = (dec_sum > {4'b0, DEC_LIMIT});

  // zero divisors act as one
  assign part_den   = (cfg.part_count == 16'd0) ? 16'd1 : cfg.part_count;
  assign region_den = (cfg.region_count == 8'd0) ? 16'd1 : {8'b0, cfg.region_count};

  // first dividend by mode
  always_comb begin
    unique case (cfg.mode)
      kpm_pkg::MODE_HASH:    first_dividend = {31'b0, hash};
      kpm_pkg::MODE_DEC_MOD: first_dividend = dec_value;
      kpm_pkg::MODE_DEC_DIV: first_dividend = dec_value;
      kpm_pkg::MODE_WORD:    first_dividend = {31'b0, wh_word - 32'd1};
      default:               first_dividend = '0;
    endcase
  end

  // one restoring division step
  assign trial      = {div_rem, div_q[kpm_pkg::DIV_W-1]};
  assign trial_diff = trial - {1'b0, div_den};
  assign trial_ge   = (trial >= {1'b0, div_den});

  // key accumulators
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_key) begin
      hash         <= kpm_pkg::FNV_BASIS;
      bytes_seen   <= '0;
      dec_value    <= '0;
      digits_ended <= 1'b0;
      number_bad   <= 1'b0;
      wh_word      <= '0;
    end else if (cmd.byte_en) begin
      if (bytes_seen < cfg.key_prefix_bytes) begin
        hash <= hash_mul ^ {24'b0, in_data.key_byte};
      end
      if (!digits_ended) begin
        if (is_digit) begin
          if (dec_over) begin
            number_bad   <= 1'b1;
            digits_ended <= 1'b1;
          end else begin
            dec_value <= dec_sum[kpm_pkg::DIV_W-1:0];
          end
        end else begin
          if (bytes_seen == 16'd0) begin
            number_bad <= 1'b1;
          end
          digits_ended <= 1'b1;
        end
      end
      if (bytes_seen < 16'd4) begin
        wh_word <= wh_word | ({24'b0, in_data.key_byte} << {bytes_seen[1:0], 3'b000});
      end
      if (bytes_seen != 16'hffff) begin
        bytes_seen <= bytes_seen + 16'd1;
      end
    end
  end

  // divider
  always_ff @(posedge clk) begin
    if (cmd.load_first) begin
      div_q   <= first_dividend;
      div_rem <= '0;
      div_den <= (cfg.mode == kpm_pkg::MODE_DEC_DIV) ? region_den : part_den;
      div_cnt <= '0;
      key_bad <= number_bad && ((cfg.mode == kpm_pkg::MODE_DEC_MOD) ||
                                (cfg.mode == kpm_pkg::MODE_DEC_DIV));
    end else if (cmd.load_second) begin
      div_rem <= '0;
      div_den <= part_den;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_q   <= {div_q[kpm_pkg::DIV_W-2:0], trial_ge};
      div_rem <= trial_ge ? trial_diff[15:0] : trial[15:0];
      div_cnt <= div_cnt + 1'b1;
    end
  end

  assign stat.div_last = (div_cnt == kpm_pkg::CNT_W'(kpm_pkg::DIV_W - 1));
  assign stat.two_pass = (cfg.mode == kpm_pkg::MODE_DEC_DIV);
  assign stat.out_free = !out_valid || out_ready;

  assign part_res = key_bad ? 16'd0 : div_rem;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.result_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      out_data.partition <= part_res;
      out_data.is_local  <= !key_bad && (part_res == cfg.own_part);
      out_data.bad_key   <= key_bad;
    end
  end

endmodule

`default_nettype wire

/* rtl/key_partition_mapper.sv */
// ----------------------------------------------------------------------------
// key_partition_mapper
// Maps a byte-serial key to a partition by fnv-1 hash, decimal value or
// little-endian word, reduced modulo the partition count.
// ----------------------------------------------------------------------------
// Key bytes are accepted one per cycle while in_ready is high. After the last
// byte the block loads the divider and runs a bit-serial restoring divider (one
// quotient bit per cycle); in mode 2 the value is first divided by the region
// count, then the divider is loaded again to reduce the quotient modulo the
// partition count. Finally the result moves into the output register. Input is
// held off from the last byte through the divide and, after it, for as long as
// an earlier result still waits in the output register; a finished result can
// wait in the output register while the next key streams in.
`default_nettype none

module key_partition_mapper (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [kpm_pkg::IDX_W-1:0]     cfg_index,
  input  wire logic [kpm_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire kpm_pkg::kpm_in_t              in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output kpm_pkg::kpm_out_t                  out_data
);

  kpm_pkg::kpm_cfg_t  cfg;
  kpm_pkg::kpm_cmd_t  cmd;
  kpm_pkg::kpm_stat_t stat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode             <= kpm_pkg::MODE_HASH;
      cfg.part_count       <= 16'd1;
      cfg.own_part         <= 16'd0;
      cfg.region_count     <= 8'd1;
      cfg.key_prefix_bytes <= 16'hffff;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kpm_pkg::REG_MODE:       cfg.mode             <= kpm_pkg::kpm_mode_t'(cfg_data[1:0]);
        kpm_pkg::REG_NUM_PART:   cfg.part_count       <= cfg_data;
        kpm_pkg::REG_LOCAL_PART: cfg.own_part         <= cfg_data;
        kpm_pkg::REG_NUM_REGION: cfg.region_count     <= cfg_data[7:0];
        kpm_pkg::REG_PREFIX:     cfg.key_prefix_bytes <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  kpm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_last  (in_data.last_byte),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  kpm_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* rtl/kpm_checker.sv */
// ----------------------------------------------------------------------------
// kpm_checker
// Port-level checks for the key partition mapper, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module kpm_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire kpm_pkg::kpm_in_t          in_data,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire kpm_pkg::kpm_out_t         out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a bad key never reports local
  a_bad_not_local: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.bad_key |-> !out_data.is_local && out_data.partition == 16'd0)
    else $error("bad key with nonzero partition or local flag");

  // input is held off while the key is being reduced
  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.last_byte |=> !in_ready)
    else $error("request accepted during divide");

  // no result straight after the last byte
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.last_byte && !out_valid |=> !out_valid)
    else $error("result appeared before divide finished");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind key_partition_mapper kpm_checker u_kpm_checker (.*);

`default_nettype wire
